FILE: rtl/core/lps_pkg.sv
// Package for the lexicographic permutation stepper.
// Holds sizes, operation and status codes and the controller/datapath structs.
// No dependencies.
package lps_pkg;

   localparam int MaxLen = 16;
   localparam int IdxW = 4;
   localparam int ValW = 4;
   localparam int LenW = 5;

   typedef enum logic [2:0] {
      FUNC_SWAP = 3'd0,
      FUNC_NEXT = 3'd1,
      FUNC_PREV = 3'd2,
      FUNC_IDENT = 3'd3,
      FUNC_READ = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_NONE = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP = 4'd0,
      DP_LOAD = 4'd1,
      DP_SWAP = 4'd2,
      DP_IDENT = 4'd3,
      DP_PIVOT = 4'd4,
      DP_SUCC = 4'd5,
      DP_XCHG = 4'd6,
      DP_REV = 4'd7,
      DP_EMIT = 4'd8,
      DP_REPLY = 4'd9
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic upward;
   } ctl_type;

   typedef struct packed {
      logic pivot_done;
      logic pivot_fail;
      logic succ_done;
      logic rev_done;
      logic emit_last;
   } dp_stat_type;

   typedef struct packed {
      logic [1:0] status;
      logic [IdxW-1:0] position;
      logic [ValW-1:0] value;
      logic last;
   } rsp_pay_type;

endpackage

FILE: rtl/core/lps_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lps_pkg.
interface lps_req_if;
   logic valid;
   logic ready;
   logic [2:0] func;
   logic [lps_pkg::IdxW-1:0] index_a;
   logic [lps_pkg::IdxW-1:0] index_b;
   modport source (output valid, func, index_a, index_b, input ready);
   modport sink (input valid, func, index_a, index_b, output ready);
endinterface

interface lps_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [lps_pkg::IdxW-1:0] position;
   logic [lps_pkg::ValW-1:0] value;
   logic last;
   modport source (output valid, status, position, value, last, input ready);
   modport sink (input valid, status, position, value, last, output ready);
endinterface

FILE: rtl/core/lps_datapath.sv
// Datapath: permutation store, scan indices and output payload formation.
// Depends on lps_pkg.
module lps_datapath (
   input  logic clock,
   input  logic reset,
   input  lps_pkg::ctl_type ctl,
   input  logic [2:0] func,
   input  logic [lps_pkg::IdxW-1:0] index_a,
   input  logic [lps_pkg::IdxW-1:0] index_b,
   input  logic [lps_pkg::LenW-1:0] perm_length,
   output lps_pkg::dp_stat_type stat,
   output lps_pkg::rsp_pay_type pay
);
   logic [lps_pkg::ValW-1:0] ent_ff [lps_pkg::MaxLen];
   logic [lps_pkg::LenW-1:0] n_ff;
   logic [2:0] func_ff;
   logic [lps_pkg::IdxW-1:0] a_ff, b_ff;
   logic [lps_pkg::LenW-1:0] i_ff, j_ff, k_ff, lo_ff, hi_ff;
   logic [lps_pkg::LenW-1:0] n_use;
   logic [lps_pkg::ValW-1:0] vi, vi1, vj, vk, vpiv;
   logic gt_i, take, a_bad, b_bad, fail_now;

   assign n_use = (perm_length > lps_pkg::LenW'(lps_pkg::MaxLen)) ?
                  lps_pkg::LenW'(lps_pkg::MaxLen) : perm_length;
   assign vi = ent_ff[i_ff[lps_pkg::IdxW-1:0]];
   assign vi1 = ent_ff[4'(i_ff + 5'd1)];
   assign vj = ent_ff[j_ff[lps_pkg::IdxW-1:0]];
   assign vk = ent_ff[k_ff[lps_pkg::IdxW-1:0]];
   assign vpiv = vi;
   assign gt_i = ctl.upward ? (vi > vi1) : (vi < vi1);
   assign take = ctl.upward ? (vj > vpiv && vj < vk) : (vj < vpiv && vj > vk);
   assign a_bad = {1'b0, a_ff} >= n_ff;
   assign b_bad = {1'b0, b_ff} >= n_ff;
   assign fail_now = (n_ff < 5'd2) || (i_ff == 5'd0 && gt_i);

   always_comb begin
      stat.pivot_fail = fail_now;
      stat.pivot_done = fail_now || !gt_i;
      stat.succ_done = (j_ff >= n_ff);
      stat.rev_done = (lo_ff >= hi_ff);
      stat.emit_last = (j_ff + 5'd1 == n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < lps_pkg::MaxLen; e++) ent_ff[e] <= lps_pkg::ValW'(e);
      end else begin
         case (ctl.cmd)
            lps_pkg::DP_LOAD: begin
               n_ff <= n_use;
               func_ff <= func;
               a_ff <= index_a;
               b_ff <= index_b;
               i_ff <= n_use - 5'd2;
            end
            lps_pkg::DP_SWAP: begin
               if (!a_bad && !b_bad) begin
                  ent_ff[a_ff] <= ent_ff[b_ff];
                  ent_ff[b_ff] <= ent_ff[a_ff];
               end
            end
            lps_pkg::DP_IDENT: begin
               for (int e = 0; e < lps_pkg::MaxLen; e++)
                  if (lps_pkg::LenW'(e) < n_ff) ent_ff[e] <= lps_pkg::ValW'(e);
            end
            lps_pkg::DP_PIVOT: begin
               if (gt_i && i_ff != 5'd0) i_ff <= i_ff - 5'd1;
               k_ff <= i_ff + 5'd1;
               j_ff <= i_ff + 5'd2;
            end
            lps_pkg::DP_SUCC: begin
               if (j_ff < n_ff) begin
                  if (take) k_ff <= j_ff;
                  j_ff <= j_ff + 5'd1;
               end
            end
            lps_pkg::DP_XCHG: begin
               ent_ff[i_ff[lps_pkg::IdxW-1:0]] <= vk;
               ent_ff[k_ff[lps_pkg::IdxW-1:0]] <= vi;
               lo_ff <= i_ff + 5'd1;
               hi_ff <= n_ff - 5'd1;
            end
            lps_pkg::DP_REV: begin
               if (lo_ff < hi_ff) begin
                  ent_ff[lo_ff[lps_pkg::IdxW-1:0]] <= ent_ff[hi_ff[lps_pkg::IdxW-1:0]];
                  ent_ff[hi_ff[lps_pkg::IdxW-1:0]] <= ent_ff[lo_ff[lps_pkg::IdxW-1:0]];
                  lo_ff <= lo_ff + 5'd1;
                  hi_ff <= hi_ff - 5'd1;
               end
               j_ff <= '0;
            end
            lps_pkg::DP_EMIT: j_ff <= j_ff + 5'd1;
            default: ;
         endcase
      end
   end

   // Payload for the current response, chosen by operation and phase.
   always_comb begin
      pay = '0;
      pay.last = 1'b1;
      if (ctl.cmd == lps_pkg::DP_EMIT) begin
         pay.position = j_ff[lps_pkg::IdxW-1:0];
         pay.value = vj;
         pay.last = stat.emit_last;
      end else begin
         case (func_ff)
            lps_pkg::FUNC_SWAP:
               pay.status = (a_bad || b_bad) ? lps_pkg::STAT_RANGE : lps_pkg::STAT_OK;
            lps_pkg::FUNC_NEXT, lps_pkg::FUNC_PREV: pay.status = lps_pkg::STAT_NONE;
            lps_pkg::FUNC_READ: begin
               pay.position = a_ff;
               pay.status = a_bad ? lps_pkg::STAT_RANGE : lps_pkg::STAT_OK;
               pay.value = a_bad ? '0 : ent_ff[a_ff];
            end
            default: pay.status = lps_pkg::STAT_OK;
         endcase
      end
   end
endmodule

FILE: rtl/core/lps_ctrl.sv
// Controller state machine sequencing one operation per item.
// Depends on lps_pkg.
module lps_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_func,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  lps_pkg::dp_stat_type stat,
   output lps_pkg::ctl_type ctl
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_DISP = 8'b00000010,
      S_PIVOT = 8'b00000100,
      S_SUCC = 8'b00001000,
      S_XCHG = 8'b00010000,
      S_REV = 8'b00100000,
      S_EMIT = 8'b01000000,
      S_REPLY = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] func_ff;
   logic up_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign ctl.upward = up_ff;

   always_comb begin
      state_in = state_ff;
      ctl.cmd = lps_pkg::DP_NOP;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd = lps_pkg::DP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (func_ff)
               lps_pkg::FUNC_SWAP: begin
                  state_in = S_REPLY;
               end
               lps_pkg::FUNC_IDENT: begin
                  ctl.cmd = lps_pkg::DP_IDENT;
                  state_in = S_REPLY;
               end
               lps_pkg::FUNC_READ: state_in = S_REPLY;
               lps_pkg::FUNC_NEXT, lps_pkg::FUNC_PREV: state_in = S_PIVOT;
               default: state_in = S_IDLE;
            endcase
         end
         S_PIVOT: begin
            ctl.cmd = lps_pkg::DP_PIVOT;
            if (stat.pivot_fail) state_in = S_REPLY;
            else if (stat.pivot_done) state_in = S_SUCC;
         end
         S_SUCC: begin
            ctl.cmd = lps_pkg::DP_SUCC;
            if (stat.succ_done) state_in = S_XCHG;
         end
         S_XCHG: begin
            ctl.cmd = lps_pkg::DP_XCHG;
            state_in = S_REV;
         end
         S_REV: begin
            ctl.cmd = lps_pkg::DP_REV;
            if (stat.rev_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.cmd = lps_pkg::DP_EMIT;
               if (stat.emit_last) state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (func_ff == lps_pkg::FUNC_SWAP) ctl.cmd = lps_pkg::DP_SWAP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == S_IDLE && req_valid) begin
         func_ff <= req_func;
         up_ff <= (req_func == lps_pkg::FUNC_NEXT);
      end
   end
endmodule

FILE: rtl/core/lexicographic_permutation_stepper.sv
// Lexicographic permutation stepper: top level with APB register and channels.
// One item at a time. A next or previous step loads, dispatches, scans for the pivot,
// scans the suffix for the successor, exchanges, reverses the suffix, then emits n
// results; a failed step replies with status none. Swap, identity and read each
// give a single result; a swap is applied when its result is taken.
// Synchronous active-high reset restores identity and perm_length 16.
module lexicographic_permutation_stepper (
   input  logic clock,
   input  logic reset,
   lps_req_if.sink req,
   lps_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   // The only register, perm_length, sits at address zero.
   logic [lps_pkg::LenW-1:0] len_ff;
   lps_pkg::ctl_type ctl;
   lps_pkg::dp_stat_type stat;
   lps_pkg::rsp_pay_type pay;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {27'd0, len_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= lps_pkg::LenW'(16);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         len_ff <= csr_pwdata[lps_pkg::LenW-1:0];
      end
   end

   // The controller sequences each item; the datapath holds the store.
   lps_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_func(req.func),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .ctl(ctl)
   );

   lps_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .func(req.func), .index_a(req.index_a), .index_b(req.index_b),
      .perm_length(len_ff), .stat(stat), .pay(pay)
   );

   assign rsp.status = pay.status;
   assign rsp.position = pay.position;
   assign rsp.value = pay.value;
   assign rsp.last = pay.last;

   // No new item is taken while a response is being offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request accepted during response");
   // After a response marked last is taken, the block returns to accepting items.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
      else $error("not idle after last response");
endmodule

FILE: tb/lexicographic_permutation_stepper_tb.sv
// Self-checking testbench for the lexicographic permutation stepper.
// Holds its own permutation predictor and drives the block through its channels.
// Depends on lps_pkg, lps_if.sv and the block's RTL.
`timescale 1ns / 1ps

module lexicographic_permutation_stepper_tb;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [3:0] value;
      logic last;
   } entry_result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   lps_req_if req ();
   lps_rsp_if rsp ();

   lexicographic_permutation_stepper dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   localparam logic [1:0] ADDR_PERM_LENGTH = 2'd0;

   // Predictor state: the permutation store and the length register.
   logic [3:0] model_perm [lps_pkg::MaxLen];
   logic [4:0] model_len;
   entry_result_type expected_results [$];
   int error_count = 0;
   bit random_stall = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("lexicographic_permutation_stepper_tb: errors");
      $finish;
   end

   function automatic int active_len();
      return (model_len > lps_pkg::MaxLen) ? lps_pkg::MaxLen : int'(model_len);
   endfunction

   function automatic void exchange(int a, int b);
      logic [3:0] t;
      t = model_perm[a];
      model_perm[a] = model_perm[b];
      model_perm[b] = t;
   endfunction

   // Steps to the neighboring permutation; upward picks next, else previous.
   function automatic bit step_permutation(int n, bit upward);
      int i, j, k;
      if (n < 2) return 1'b0;
      i = n - 2;
      while (i != 0 && (upward ? model_perm[i] > model_perm[i+1]
                               : model_perm[i] < model_perm[i+1]))
         i--;
      if (i == 0 && (upward ? model_perm[0] > model_perm[1]
                            : model_perm[0] < model_perm[1]))
         return 1'b0;
      k = i + 1;
      for (j = i + 2; j < n; j++) begin
         if (upward ? (model_perm[j] > model_perm[i] && model_perm[j] < model_perm[k])
                    : (model_perm[j] < model_perm[i] && model_perm[j] > model_perm[k]))
            k = j;
      end
      exchange(i, k);
      for (j = i + 1; j <= (n + i) / 2; j++)
         exchange(j, n + i - j);
      return 1'b1;
   endfunction

   function automatic void push_single(lps_pkg::status_type st, logic [3:0] pos,
                                       logic [3:0] val);
      expected_results.push_back('{st, pos, val, 1'b1});
   endfunction

   // Works out every result that one item causes and queues it.
   function automatic void predict_operation(logic [2:0] f, logic [3:0] a, logic [3:0] b);
      int n;
      n = active_len();
      case (f)
         lps_pkg::FUNC_SWAP: begin
            if (a >= n || b >= n) push_single(lps_pkg::STAT_RANGE, 0, 0);
            else begin
               exchange(a, b);
               push_single(lps_pkg::STAT_OK, 0, 0);
            end
         end
         lps_pkg::FUNC_NEXT, lps_pkg::FUNC_PREV: begin
            if (!step_permutation(n, f == lps_pkg::FUNC_NEXT))
               push_single(lps_pkg::STAT_NONE, 0, 0);
            else
               for (int i = 0; i < n; i++)
                  expected_results.push_back('{lps_pkg::STAT_OK, 4'(i), model_perm[i],
                                               i == n - 1});
         end
         lps_pkg::FUNC_IDENT: begin
            for (int i = 0; i < n; i++) model_perm[i] = 4'(i);
            push_single(lps_pkg::STAT_OK, 0, 0);
         end
         lps_pkg::FUNC_READ: begin
            if (a < n) push_single(lps_pkg::STAT_OK, a, model_perm[a]);
            else push_single(lps_pkg::STAT_RANGE, a, 0);
         end
         default: ;
      endcase
   endfunction

   // Result side: random stalls, and each accepted result is checked in order.
   initial begin
      int gap;
      rsp.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = random_stall ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock iff rsp.valid);
         begin
            entry_result_type got, want;
            got = '{rsp.status, rsp.position, rsp.value, rsp.last};
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display({"%0t mismatch: expected st=%0d pos=%0d val=%0d last=%0d,",
                            " actual st=%0d pos=%0d val=%0d last=%0d"},
                           $time, want.status, want.position, want.value, want.last,
                           got.status, got.position, got.value, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Valid stays high after an accepted item until the next gap or a drain.
   task automatic send_item(logic [2:0] f, logic [3:0] a, logic [3:0] b);
      int gap;
      gap = random_stall ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func <= f;
      req.index_a <= a;
      req.index_b <= b;
      @(posedge clock iff req.ready);
      predict_operation(f, a, b);
   endtask

   // Waits until the block has delivered everything and is idle again.
   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (expected_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_length(logic [4:0] len);
      drain();
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_PERM_LENGTH; csr_pwdata <= 32'(len);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      model_len = len;
   endtask

   task automatic test_directed_full_length();
      send_item(lps_pkg::FUNC_READ, 4'd15, 4'd0);
      send_item(lps_pkg::FUNC_PREV, 0, 0);        // identity has no predecessor
      send_item(lps_pkg::FUNC_NEXT, 0, 0);
      send_item(lps_pkg::FUNC_SWAP, 4'd0, 4'd15);
      send_item(lps_pkg::FUNC_SWAP, 4'd7, 4'd7);  // equal indices change nothing
      send_item(lps_pkg::FUNC_PREV, 0, 0);
      send_item(lps_pkg::FUNC_IDENT, 0, 0);
      send_item(3'd5, 4'hF, 4'hF);                // unused codes are dropped
      send_item(3'd7, 4'h0, 4'h0);
      send_item(3'd6, 4'hA, 4'h5);
   endtask

   task automatic test_length_edges();
      write_length(5'd2);
      send_item(lps_pkg::FUNC_NEXT, 0, 0);
      send_item(lps_pkg::FUNC_NEXT, 0, 0);        // last permutation reached
      send_item(lps_pkg::FUNC_SWAP, 4'd1, 4'd2);  // out of range
      send_item(lps_pkg::FUNC_READ, 4'd3, 0);
      write_length(5'd1);
      send_item(lps_pkg::FUNC_NEXT, 0, 0);
      send_item(lps_pkg::FUNC_PREV, 0, 0);
      write_length(5'd0);
      send_item(lps_pkg::FUNC_READ, 4'd0, 0);
      send_item(lps_pkg::FUNC_SWAP, 4'd0, 4'd0);
      send_item(lps_pkg::FUNC_IDENT, 0, 0);
      send_item(lps_pkg::FUNC_NEXT, 0, 0);
      write_length(5'd31);                        // saturates to the full store
      send_item(lps_pkg::FUNC_NEXT, 0, 0);
      send_item(lps_pkg::FUNC_READ, 4'd15, 0);
   endtask

   task automatic test_random_walk();
      logic [2:0] f;
      int pick;
      for (int i = 0; i < 200; i++) begin
         if (i % 40 == 0)
            write_length(($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(2, 6)));
         if (i == 100) begin
            random_stall = 1'b0;  // a stretch with no idling at either side
         end
         if (i == 130) random_stall = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick < 7) f = lps_pkg::FUNC_NEXT;
         else if (pick < 12) f = lps_pkg::FUNC_PREV;
         else if (pick < 15) f = lps_pkg::FUNC_SWAP;
         else if (pick < 17) f = lps_pkg::FUNC_READ;
         else if (pick < 18) f = lps_pkg::FUNC_IDENT;
         else f = 3'($urandom_range(0, 7));
         send_item(f, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         if (i == 60) drain();   // hold off until every result has come
      end
   endtask

   initial begin
      for (int i = 0; i < lps_pkg::MaxLen; i++) model_perm[i] = 4'(i);
      model_len = 5'd16;
      req.valid <= 1'b0; req.func <= '0; req.index_a <= '0; req.index_b <= '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_full_length();
      test_length_edges();
      test_random_walk();
      write_length(5'd16);
      send_item(lps_pkg::FUNC_IDENT, 0, 0);
      drain();
      if (error_count == 0 && expected_results.size() == 0)
         $display("lexicographic_permutation_stepper_tb: clean");
      else
         $display("lexicographic_permutation_stepper_tb: errors");
      $finish;
   end

endmodule
